@@ design/msc_pkg.sv @@
`default_nettype none

package msc_pkg;

  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 16;
  localparam int COUNT_W  = 13;
  localparam int RANGE_W  = 3;
  localparam int OFFSET_W = 17;
  localparam int GAIN_W   = 16;
  localparam int RECIP_W  = 17;
  localparam int FIELD_W  = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // count times reciprocal, then gauss, difference, scaled product
  localparam int PROD_W  = 31;
  localparam int GAUSS_W = 18;
  localparam int DIFF_W  = 19;
  localparam int SCALE_W = 36;
  localparam int SHIFT_G = 12;
  localparam int SHIFT_S = 14;
  localparam int FULL_W  = SCALE_W - SHIFT_S;

  localparam int AXIS_LIMIT = 2048;
  localparam int FIELD_MAX  = 131071;
  localparam int FIELD_MIN  = -131072;

  localparam logic [RANGE_W-1:0] RANGE_RESET = RANGE_W'(1);
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(16384);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_SEL = 3'd0,
    REG_X_OFFSET  = 3'd1,
    REG_Y_OFFSET  = 3'd2,
    REG_Z_OFFSET  = 3'd3,
    REG_X_GAIN    = 3'd4,
    REG_Y_GAIN    = 3'd5,
    REG_Z_GAIN    = 3'd6
  } cfg_reg_t;

  // round(2^24 / counts per gauss), one entry per range code
  function automatic logic [RECIP_W-1:0] recip_lookup(input logic [RANGE_W-1:0] sel);
    logic [RECIP_W-1:0] r;
    case (sel)
      3'd0: r = 17'd12246;
      3'd1: r = 17'd15392;
      3'd2: r = 17'd20460;
      3'd3: r = 17'd25420;
      3'd4: r = 17'd38130;
      3'd5: r = 17'd43019;
      3'd6: r = 17'd50840;
      3'd7: r = 17'd72944;
      default: r = 17'd15392;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/magnetometer_sample_conditioner.sv @@
`default_nettype none

// Six-stage pipeline: a report taken with start (busy is never high) gives its
// result on the done strobe, and a new report may be taken every cycle. The
// result is shown for one cycle only, since the receiver cannot stall; capture
// it when done is high. The two multiplier stages (count by reciprocal,
// difference by gain) are each followed by their own rounding stage.
// Configuration writes are always ready and take effect on the next report;
// write them only while no report is in flight.
module magnetometer_sample_conditioner
  import msc_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [BYTE_W-1:0]            x_high,
  input  wire logic [BYTE_W-1:0]            x_low,
  input  wire logic [BYTE_W-1:0]            z_high,
  input  wire logic [BYTE_W-1:0]            z_low,
  input  wire logic [BYTE_W-1:0]            y_high,
  input  wire logic [BYTE_W-1:0]            y_low,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_DATA_W-1:0]        cfg_data,
  output logic                              done,
  output logic                              valid_res,
  output logic signed [COUNT_W-1:0]         raw_x,
  output logic signed [COUNT_W-1:0]         raw_y,
  output logic signed [COUNT_W-1:0]         raw_z,
  output logic signed [FIELD_W-1:0]         field_x,
  output logic signed [FIELD_W-1:0]         field_y,
  output logic signed [FIELD_W-1:0]         field_z
);

  // configuration registers
  logic [RANGE_W-1:0]         range_sel;
  logic signed [OFFSET_W-1:0] offset [3];
  logic [GAIN_W-1:0]          gain [3];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_sel <= RANGE_RESET;
      for (int i = 0; i < 3; i++) begin
        offset[i] <= '0;
        gain[i]   <= GAIN_RESET;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_RANGE_SEL: range_sel <= cfg_data[RANGE_W-1:0];
        REG_X_OFFSET:  offset[0] <= $signed(cfg_data[OFFSET_W-1:0]);
        REG_Y_OFFSET:  offset[1] <= $signed(cfg_data[OFFSET_W-1:0]);
        REG_Z_OFFSET:  offset[2] <= $signed(cfg_data[OFFSET_W-1:0]);
        REG_X_GAIN:    gain[0]   <= cfg_data[GAIN_W-1:0];
        REG_Y_GAIN:    gain[1]   <= cfg_data[GAIN_W-1:0];
        REG_Z_GAIN:    gain[2]   <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // valid bits, one per stage
  logic v1, v2, v3, v4, v5, v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // stage 1: capture the sensor words
  logic signed [WORD_W-1:0] sx1, sy1, sz1;

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      sx1 <= $signed({x_high, x_low});
      sy1 <= $signed({y_high, y_low});
      sz1 <= $signed({z_high, z_low});
    end
  end

  // stage 2: range check, board remap, reciprocal lookup
  logic in_range;
  logic signed [WORD_W-1:0] neg_sx, neg_sy;

  assign in_range = (sx1 <= WORD_W'(AXIS_LIMIT)) && (sx1 >= -WORD_W'(AXIS_LIMIT)) &&
                    (sy1 <= WORD_W'(AXIS_LIMIT)) && (sy1 >= -WORD_W'(AXIS_LIMIT)) &&
                    (sz1 <= WORD_W'(AXIS_LIMIT)) && (sz1 >= -WORD_W'(AXIS_LIMIT));
  assign neg_sx = -sx1;
  assign neg_sy = -sy1;

  logic                      ok2;
  logic signed [COUNT_W-1:0] raw2 [3];
  logic signed [COUNT_W-1:0] cnt2 [3];
  logic [RECIP_W-1:0]        recip2;

  always_ff @(posedge clk) begin
    ok2     <= in_range;
    raw2[0] <= sy1[COUNT_W-1:0];
    raw2[1] <= neg_sx[COUNT_W-1:0];
    raw2[2] <= sz1[COUNT_W-1:0];
    cnt2[0] <= neg_sy[COUNT_W-1:0];
    cnt2[1] <= sx1[COUNT_W-1:0];
    cnt2[2] <= sz1[COUNT_W-1:0];
    recip2  <= recip_lookup(range_sel);
  end

  // stage 3: count times reciprocal
  logic                      ok3;
  logic signed [COUNT_W-1:0] raw3 [3];
  logic signed [PROD_W-1:0]  prod3 [3];

  always_ff @(posedge clk) begin
    ok3 <= ok2;
    for (int i = 0; i < 3; i++) begin
      raw3[i]  <= raw2[i];
      prod3[i] <= PROD_W'(cnt2[i]) * $signed(PROD_W'({1'b0, recip2}));
    end
  end

  // stage 4: round to Q.12 gauss and subtract the offset
  logic signed [PROD_W-1:0]  prod_rnd [3];
  logic signed [GAUSS_W-1:0] gauss [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_rnd[i] = prod3[i] + PROD_W'(1 << (SHIFT_G - 1));
      gauss[i]    = prod_rnd[i][SHIFT_G +: GAUSS_W];
    end
  end

  logic                      ok4;
  logic signed [COUNT_W-1:0] raw4 [3];
  logic signed [DIFF_W-1:0]  diff4 [3];

  always_ff @(posedge clk) begin
    ok4 <= ok3;
    for (int i = 0; i < 3; i++) begin
      raw4[i]  <= raw3[i];
      diff4[i] <= DIFF_W'(gauss[i]) - DIFF_W'(offset[i]);
    end
  end

  // stage 5: difference times gain
  logic                      ok5;
  logic signed [COUNT_W-1:0] raw5 [3];
  logic signed [SCALE_W-1:0] scale5 [3];

  always_ff @(posedge clk) begin
    ok5 <= ok4;
    for (int i = 0; i < 3; i++) begin
      raw5[i]   <= raw4[i];
      scale5[i] <= SCALE_W'(diff4[i]) * $signed(SCALE_W'({1'b0, gain[i]}));
    end
  end

  // stage 6: round, saturate, zero the result of an out-of-range report
  logic signed [SCALE_W-1:0] scale_rnd [3];
  logic signed [FULL_W-1:0]  full [3];
  logic signed [FIELD_W-1:0] sat [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      scale_rnd[i] = scale5[i] + SCALE_W'(1 << (SHIFT_S - 1));
      full[i]      = scale_rnd[i][SHIFT_S +: FULL_W];
      if (full[i] > FULL_W'(FIELD_MAX)) begin
        sat[i] = FIELD_W'(FIELD_MAX);
      end else if (full[i] < FULL_W'(FIELD_MIN)) begin
        sat[i] = FIELD_W'(FIELD_MIN);
      end else begin
        sat[i] = full[i][FIELD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    valid_res <= ok5;
    raw_x     <= ok5 ? raw5[0] : '0;
    raw_y     <= ok5 ? raw5[1] : '0;
    raw_z     <= ok5 ? raw5[2] : '0;
    field_x   <= ok5 ? sat[0] : '0;
    field_y   <= ok5 ? sat[1] : '0;
    field_z   <= ok5 ? sat[2] : '0;
  end

  assign done = v6;

endmodule

`default_nettype wire

@@ test/mag_field_checker.sv @@
`timescale 1ns / 100ps

module mag_field_checker
  import msc_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic                         busy,
  input  wire logic [BYTE_W-1:0]            x_high,
  input  wire logic [BYTE_W-1:0]            x_low,
  input  wire logic [BYTE_W-1:0]            z_high,
  input  wire logic [BYTE_W-1:0]            z_low,
  input  wire logic [BYTE_W-1:0]            y_high,
  input  wire logic [BYTE_W-1:0]            y_low,
  input  wire logic                         cfg_valid,
  input  wire logic                         cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_DATA_W-1:0]        cfg_data,
  input  wire logic                         done,
  input  wire logic                         valid_res,
  input  wire logic signed [COUNT_W-1:0]    raw_x,
  input  wire logic signed [COUNT_W-1:0]    raw_y,
  input  wire logic signed [COUNT_W-1:0]    raw_z,
  input  wire logic signed [FIELD_W-1:0]    field_x,
  input  wire logic signed [FIELD_W-1:0]    field_y,
  input  wire logic signed [FIELD_W-1:0]    field_z,
  output int                                mismatch_count,
  output int                                reports_in_flight
);

  typedef struct packed {
    logic                      valid_res;
    logic signed [COUNT_W-1:0] raw_x;
    logic signed [COUNT_W-1:0] raw_y;
    logic signed [COUNT_W-1:0] raw_z;
    logic signed [FIELD_W-1:0] field_x;
    logic signed [FIELD_W-1:0] field_y;
    logic signed [FIELD_W-1:0] field_z;
  } mag_result_t;

  // local copy of the calibration registers
  logic [RANGE_W-1:0] range_code;
  longint             offset_q12 [3];
  longint             gain_q14 [3];
  longint             recip_q24 [8];

  mag_result_t        pending_fields [$];

  initial recip_q24 = '{12246, 15392, 20460, 25420, 38130, 43019, 50840, 72944};

  function automatic bit beyond_limit(input logic signed [WORD_W-1:0] w);
    return (w > AXIS_LIMIT) || (w < -AXIS_LIMIT);
  endfunction

  // counts to gauss, remove offset, apply gain; both roundings are to nearest, ties toward +inf
  function automatic logic signed [FIELD_W-1:0] to_gauss_field(input longint count,
                                                               input int axis);
    longint g;
    longint d;
    longint f;
    g = (count * recip_q24[range_code] + (longint'(1) << (SHIFT_G - 1))) >>> SHIFT_G;
    d = g - offset_q12[axis];
    f = (d * gain_q14[axis] + (longint'(1) << (SHIFT_S - 1))) >>> SHIFT_S;
    if (f > FIELD_MAX) f = FIELD_MAX;
    else if (f < FIELD_MIN) f = FIELD_MIN;
    return f[FIELD_W-1:0];
  endfunction

  function automatic mag_result_t condition_report(input logic [BYTE_W-1:0] xh, xl,
                                                   input logic [BYTE_W-1:0] zh, zl,
                                                   input logic [BYTE_W-1:0] yh, yl);
    logic signed [WORD_W-1:0] sx;
    logic signed [WORD_W-1:0] sz;
    logic signed [WORD_W-1:0] sy;
    longint                   lx;
    longint                   ly;
    longint                   lz;
    longint                   neg_x;
    mag_result_t              r;
    sx = {xh, xl};
    sz = {zh, zl};
    sy = {yh, yl};
    r = '0;
    if (beyond_limit(sx) || beyond_limit(sz) || beyond_limit(sy)) return r;
    lx = sx;
    ly = sy;
    lz = sz;
    neg_x = -lx;
    r.valid_res = 1'b1;
    r.raw_x = ly[COUNT_W-1:0];
    r.raw_y = neg_x[COUNT_W-1:0];
    r.raw_z = lz[COUNT_W-1:0];
    r.field_x = to_gauss_field(-ly, 0);
    r.field_y = to_gauss_field(lx, 1);
    r.field_z = to_gauss_field(lz, 2);
    return r;
  endfunction

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    mag_result_t want;
    if (rst) begin
      range_code = RANGE_RESET;
      for (int i = 0; i < 3; i++) begin
        offset_q12[i] = 0;
        gain_q14[i] = longint'(GAIN_RESET);
      end
      pending_fields.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RANGE_SEL: range_code = cfg_data[RANGE_W-1:0];
          REG_X_OFFSET:  offset_q12[0] = longint'($signed(cfg_data));
          REG_Y_OFFSET:  offset_q12[1] = longint'($signed(cfg_data));
          REG_Z_OFFSET:  offset_q12[2] = longint'($signed(cfg_data));
          REG_X_GAIN:    gain_q14[0] = longint'(cfg_data[GAIN_W-1:0]);
          REG_Y_GAIN:    gain_q14[1] = longint'(cfg_data[GAIN_W-1:0]);
          REG_Z_GAIN:    gain_q14[2] = longint'(cfg_data[GAIN_W-1:0]);
          default: ;
        endcase
      end
      if (done) begin
        if (pending_fields.size() == 0) begin
          $error("result strobe with no report outstanding");
          mismatch_count++;
        end else begin
          want = pending_fields.pop_front();
          compare_field("valid_res", want.valid_res, valid_res);
          compare_field("raw_x", want.raw_x, raw_x);
          compare_field("raw_y", want.raw_y, raw_y);
          compare_field("raw_z", want.raw_z, raw_z);
          compare_field("field_x", want.field_x, field_x);
          compare_field("field_y", want.field_y, field_y);
          compare_field("field_z", want.field_z, field_z);
        end
      end
      // report transfer: start high while busy is low
      if (start && !busy)
        pending_fields.push_back(condition_report(x_high, x_low, z_high, z_low,
                                                  y_high, y_low));
    end
    reports_in_flight <= pending_fields.size();
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import msc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(7);

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic [BYTE_W-1:0]         x_high = '0;
  logic [BYTE_W-1:0]         x_low = '0;
  logic [BYTE_W-1:0]         z_high = '0;
  logic [BYTE_W-1:0]         z_low = '0;
  logic [BYTE_W-1:0]         y_high = '0;
  logic [BYTE_W-1:0]         y_low = '0;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = REG_RANGE_SEL;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;
  logic                      done;
  logic                      valid_res;
  logic signed [COUNT_W-1:0] raw_x;
  logic signed [COUNT_W-1:0] raw_y;
  logic signed [COUNT_W-1:0] raw_z;
  logic signed [FIELD_W-1:0] field_x;
  logic signed [FIELD_W-1:0] field_y;
  logic signed [FIELD_W-1:0] field_z;
  int                        mismatch_count;
  int                        reports_in_flight;

  int                        sender_idle = 38;
  int unsigned               cycle_count = 0;

  magnetometer_sample_conditioner DUT (.*);

  mag_field_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic send_words(input logic [WORD_W-1:0] xw, zw, yw);
    while ($urandom_range(99) < sender_idle) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    {x_high, x_low} <= xw;
    {z_high, z_low} <= zw;
    {y_high, y_low} <= yw;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    int sel;
    sel = $urandom_range(15);
    if (sel < 13) return WORD_W'($urandom_range(4096)) - WORD_W'(2048);
    if (sel == 13) begin
      case ($urandom_range(3))
        0: return WORD_W'(2048);
        1: return -WORD_W'(2048);
        2: return WORD_W'(2049);
        default: return -WORD_W'(2049);
      endcase
    end
    if (sel == 14) return WORD_W'($urandom_range(8)) - WORD_W'(4);
    return WORD_W'($urandom);
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // unused upper data bits carry noise; a write to the spare index must be ignored
  task automatic load_config(input logic [RANGE_W-1:0] rng,
                             input logic [OFFSET_W-1:0] xo, yo, zo,
                             input logic [GAIN_W-1:0] xg, yg, zg);
    cfg_write(REG_RANGE_SEL, {(CFG_DATA_W-RANGE_W)'($urandom), rng});
    cfg_write(REG_X_OFFSET, xo);
    cfg_write(REG_Y_OFFSET, yo);
    cfg_write(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_write(REG_Z_OFFSET, zo);
    cfg_write(REG_X_GAIN, {1'($urandom), xg});
    cfg_write(REG_Y_GAIN, {1'($urandom), yg});
    cfg_write(REG_Z_GAIN, {1'($urandom), zg});
  endtask

  function automatic logic [OFFSET_W-1:0] pick_offset();
    if ($urandom_range(1)) return OFFSET_W'($urandom);
    return OFFSET_W'($urandom_range(16383)) - OFFSET_W'(8192);
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    if ($urandom_range(1)) return GAIN_W'($urandom);
    return GAIN_W'($urandom_range(20000) + 6000);
  endfunction

  // every item gives a result, so an empty checker queue means the pipe is idle
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (reports_in_flight != 0) @(negedge clk);
  endtask

  task automatic send_corners();
    send_words(WORD_W'(2048), -WORD_W'(2048), WORD_W'(2048));
    send_words(-WORD_W'(2048), WORD_W'(2048), -WORD_W'(2048));
    send_words(WORD_W'(1), -WORD_W'(1), '0);
    send_words('0, '0, '0);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // reset calibration: axis limits, most negative word, wrap patterns
    send_words('0, '0, '0);
    send_words(WORD_W'(2048), WORD_W'(2048), WORD_W'(2048));
    send_words(-WORD_W'(2048), -WORD_W'(2048), -WORD_W'(2048));
    send_words(WORD_W'(2049), '0, '0);
    send_words('0, -WORD_W'(2049), '0);
    send_words('0, '0, 16'h8000);
    send_words(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_words(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_words(WORD_W'(1), -WORD_W'(1), WORD_W'(1234));
    send_words(16'h00FF, 16'hFF00, 16'h0100);
    send_words(16'h0555, 16'hFAAA, 16'h0800);
    send_words(16'hAAAA, 16'h5555, 16'h0000);

    for (int p = 0; p < 8; p++) begin
      sender_idle = (p < 3) ? 38 : (p < 6) ? 47 : 0;
      if (p > 0) begin
        drain();
        case (p)
          1: load_config(RANGE_W'(7), 17'h0FFFF, 17'h10000, 17'h0FFFF,
                         16'hFFFF, 16'hFFFF, 16'hFFFF);
          2: load_config('0, 17'h10000, 17'h0FFFF, 17'h10000, '0, '0, '0);
          default: load_config(RANGE_W'($urandom_range(7)), pick_offset(), pick_offset(),
                               pick_offset(), pick_gain(), pick_gain(), pick_gain());
        endcase
        if (p < 3) send_corners();
      end
      repeat (50) send_words(pick_word(), pick_word(), pick_word());
    end

    drain();
    repeat (12) @(negedge clk);
    if (mismatch_count == 0 && reports_in_flight == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
